/* sv/wsfd_pkg.sv */
`timescale 1ns / 1ps

package wsfd_pkg;

   localparam int unsigned LEN_W = 63;

   // Seven-bit length codes in header byte 1 that announce an extended length
   localparam logic [6:0] LEN_EXT16 = 7'h7E;
   localparam logic [6:0] LEN_EXT64 = 7'h7F;

   // Byte counts of the extended length and mask key fields, taken at the last byte of each field
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

   localparam logic       EV_HEADER  = 1'b0;
   localparam logic       EV_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_MASK,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic             event_res;
      logic             fin;
      logic [3:0]       opcode;
      logic             masked;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       payload_byte;
      logic             last;
   } rsp_type;

endpackage

/* sv/websocket_frame_deframer.sv */
`timescale 1ns / 1ps

// WebSocket frame deframer. Takes the raw frame stream one byte per beat and
// returns one header beat when a frame header is complete (FIN, opcode, mask
// flag, 63-bit payload length; last is set when the payload is empty), then
// one beat per payload byte, unmasked with the key byte chosen by position
// mod 4, the final one marked last. Extended 16-bit and 64-bit lengths are
// big-endian; the top bit of a 64-bit length is dropped and RSV bits are
// ignored. Throughput is one byte per clock: the parser updates its state in
// the cycle a byte is taken, and results go through a result register backed
// by a one-entry skid register, so req_stall rises only when both hold a beat.
// Header and extension bytes that do not finish a header give no beat.
module websocket_frame_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_event_res,
   output logic                            rsp_fin,
   output logic [3:0]                      rsp_opcode,
   output logic                            rsp_masked,
   output logic [wsfd_pkg::LEN_W-1:0]      rsp_payload_length,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_last
);

   logic               req_take;
   logic               rsp_pop;
   logic               new_valid;
   wsfd_pkg::rsp_type  new_res;

   logic               out_valid_ff, out_valid_in;
   wsfd_pkg::rsp_type  out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   wsfd_pkg::rsp_type  skid_ff, skid_in;

   // Hold input only while the skid register is occupied
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_pop   = out_valid_ff && !rsp_stall;

   wsfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .data_byte (req_data_byte),
      .res_valid (new_valid),
      .res       (new_res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // Input is stalled; advance the skid beat once the output drains
         if (rsp_pop) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_pop) begin
         out_valid_in = req_take && new_valid;
         out_in       = new_res;
      end else if (req_take && new_valid) begin
         // Output held by the sink; park the new beat
         skid_valid_in = 1'b1;
         skid_in       = new_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_res      = out_ff.event_res;
   assign rsp_fin            = out_ff.fin;
   assign rsp_opcode         = out_ff.opcode;
   assign rsp_masked         = out_ff.masked;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_last           = out_ff.last;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat without an output beat");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_pop |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid beat lost or overwritten");

   a_skid_moves_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_pop |=> out_valid_ff && out_ff == $past(skid_ff))
      else $error("skid beat not moved to output");

endmodule

/* sv/wsfd_parse.sv */
`timescale 1ns / 1ps

module wsfd_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   output logic                res_valid,
   output wsfd_pkg::rsp_type   res
);

   wsfd_pkg::phase_type             phase_ff, phase_in;
   logic [2:0]                      cnt_ff, cnt_in;
   logic                            fin_ff, fin_in;
   logic [3:0]                      opc_ff, opc_in;
   logic                            mask_ff, mask_in;
   logic [wsfd_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [31:0]                     key_ff, key_in;
   logic [wsfd_pkg::LEN_W-1:0]      left_ff, left_in;
   logic [1:0]                      kidx_ff, kidx_in;

   logic                            is_ext16, is_ext64, after_len, hdr_done, len_zero;
   logic                            data_last;
   logic [7:0]                      key_byte;

   // Datapath and result
   always_comb begin
      fin_in    = fin_ff;
      opc_in    = opc_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      kidx_in   = kidx_ff;
      is_ext16  = (data_byte[6:0] == wsfd_pkg::LEN_EXT16);
      is_ext64  = (data_byte[6:0] == wsfd_pkg::LEN_EXT64);
      after_len = 1'b0;
      hdr_done  = 1'b0;
      data_last = (left_ff == {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1});

      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!mask_ff) begin
         key_byte = 8'h00;
      end

      case (phase_ff)
         wsfd_pkg::PH_HDR0: begin
            fin_in = data_byte[7];
            opc_in = data_byte[3:0];
         end
         wsfd_pkg::PH_HDR1: begin
            mask_in   = data_byte[7];
            cnt_in    = 3'd0;
            len_in    = (is_ext16 || is_ext64) ? '0
                        : {{(wsfd_pkg::LEN_W-7){1'b0}}, data_byte[6:0]};
            after_len = !(is_ext16 || is_ext64);
         end
         wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
            len_in    = {len_ff[wsfd_pkg::LEN_W-9:0], data_byte};
            cnt_in    = cnt_ff + 3'd1;
            after_len = (phase_ff == wsfd_pkg::PH_EXT16) ? (cnt_ff == wsfd_pkg::EXT16_LAST)
                                                          : (cnt_ff == wsfd_pkg::EXT64_LAST);
         end
         wsfd_pkg::PH_MASK: begin
            key_in   = {key_ff[23:0], data_byte};
            cnt_in   = cnt_ff + 3'd1;
            hdr_done = (cnt_ff == wsfd_pkg::KEY_LAST);
         end
         wsfd_pkg::PH_DATA: begin
            left_in = left_ff - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
            kidx_in = kidx_ff + 2'd1;
         end
         default: begin
         end
      endcase

      if (after_len) begin
         cnt_in = 3'd0;
         if (mask_in) begin
            key_in = '0;
         end else begin
            hdr_done = 1'b1;
         end
      end
      len_zero = (len_in == '0);
      if (hdr_done) begin
         cnt_in  = 3'd0;
         kidx_in = 2'd0;
         left_in = len_in;
      end

      res_valid          = hdr_done || (phase_ff == wsfd_pkg::PH_DATA);
      res.event_res      = (phase_ff == wsfd_pkg::PH_DATA) ? wsfd_pkg::EV_PAYLOAD
                                                           : wsfd_pkg::EV_HEADER;
      res.fin            = fin_in;
      res.opcode         = opc_in;
      res.masked         = mask_in;
      res.payload_length = len_in;
      res.payload_byte   = (phase_ff == wsfd_pkg::PH_DATA) ? (data_byte ^ key_byte) : 8'h00;
      res.last           = (phase_ff == wsfd_pkg::PH_DATA) ? data_last : len_zero;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         wsfd_pkg::PH_HDR0: phase_in = wsfd_pkg::PH_HDR1;
         wsfd_pkg::PH_HDR1: begin
            if (is_ext16) begin
               phase_in = wsfd_pkg::PH_EXT16;
            end else if (is_ext64) begin
               phase_in = wsfd_pkg::PH_EXT64;
            end
         end
         wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64, wsfd_pkg::PH_MASK: begin
         end
         wsfd_pkg::PH_DATA: begin
            if (data_last) begin
               phase_in = wsfd_pkg::PH_HDR0;
            end
         end
         default: phase_in = wsfd_pkg::PH_HDR0;
      endcase
      if (after_len && mask_in) begin
         phase_in = wsfd_pkg::PH_MASK;
      end
      if (hdr_done) begin
         phase_in = len_zero ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfd_pkg::PH_HDR0;
         cnt_ff   <= 3'd0;
         fin_ff   <= 1'b0;
         opc_ff   <= 4'd0;
         mask_ff  <= 1'b0;
         len_ff   <= '0;
         key_ff   <= '0;
         left_ff  <= '0;
         kidx_ff  <= 2'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         opc_ff   <= opc_in;
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         left_ff  <= left_in;
         kidx_ff  <= kidx_in;
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsfd_pkg::PH_DATA |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_key_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsfd_pkg::PH_MASK |-> cnt_ff <= wsfd_pkg::KEY_LAST)
      else $error("mask key count overran");

endmodule
